@@ rtl/asconp_pkg.sv @@
// Shared types, constants and round functions for the Ascon permutation core.
package asconp_pkg;

    localparam int unsigned WORD_W             = 64;
    localparam int unsigned NUM_WORDS          = 5;
    localparam int unsigned ROUND_CNT_W        = 5;
    localparam int unsigned RC_IDX_W           = 4;
    localparam int unsigned RC_TABLE_DEPTH     = 16;
    localparam int unsigned MAX_ROUNDS_DEFAULT = 16;

    // Round index value that marks the end of the schedule.
    localparam logic [ROUND_CNT_W-1:0] LAST_IDX = ROUND_CNT_W'(RC_TABLE_DEPTH);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] perm_state_t;

    typedef struct packed {
        word_t                  word_0;
        word_t                  word_1;
        word_t                  word_2;
        word_t                  word_3;
        word_t                  word_4;
        logic [ROUND_CNT_W-1:0] round_count;
    } item_beat_t;

    typedef struct packed {
        word_t out_word_0;
        word_t out_word_1;
        word_t out_word_2;
        word_t out_word_3;
        word_t out_word_4;
    } result_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                step;
        logic                xfer;
        logic [RC_IDX_W-1:0] rc_idx;
    } dp_cmd_t;

    function automatic logic [7:0] rc_lookup(logic [RC_IDX_W-1:0] idx);
        logic [7:0] rc;
        unique case (idx)
            4'd0:  rc = 8'h3c;
            4'd1:  rc = 8'h2d;
            4'd2:  rc = 8'h1e;
            4'd3:  rc = 8'h0f;
            4'd4:  rc = 8'hf0;
            4'd5:  rc = 8'he1;
            4'd6:  rc = 8'hd2;
            4'd7:  rc = 8'hc3;
            4'd8:  rc = 8'hb4;
            4'd9:  rc = 8'ha5;
            4'd10: rc = 8'h96;
            4'd11: rc = 8'h87;
            4'd12: rc = 8'h78;
            4'd13: rc = 8'h69;
            4'd14: rc = 8'h5a;
            4'd15: rc = 8'h4b;
        endcase
        return rc;
    endfunction

    function automatic word_t ror64(word_t x, int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    // One full round: constant addition, S-box layer, linear diffusion.
    function automatic perm_state_t perm_round(perm_state_t s, logic [7:0] rc);
        word_t       x0;
        word_t       x1;
        word_t       x2;
        word_t       x3;
        word_t       x4;
        word_t       t0;
        word_t       t1;
        word_t       t2;
        word_t       t3;
        word_t       t4;
        perm_state_t r;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {56'd0, rc};
        x3 = s[3];
        x4 = s[4];

        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;

        r[0] = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
        r[1] = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
        r[2] = x2 ^ ror64(x2, 1)  ^ ror64(x2, 6);
        r[3] = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
        r[4] = x4 ^ ror64(x4, 7)  ^ ror64(x4, 41);
        return r;
    endfunction

endpackage

@@ rtl/asconp_datapath.sv @@
// State register, shared round unit and result register of the permutation core.
module asconp_datapath (
    input  logic                      clk,
    input  asconp_pkg::dp_cmd_t       cmd,
    input  asconp_pkg::item_beat_t    item,
    output asconp_pkg::result_beat_t  result
);
    import asconp_pkg::*;

    perm_state_t  state_reg;
    perm_state_t  state_next;
    result_beat_t result_reg;

    always_comb
    begin
        state_next = state_reg;
        if (cmd.load)
        begin
            state_next = {item.word_4, item.word_3, item.word_2, item.word_1, item.word_0};
        end
        else if (cmd.step)
        begin
            state_next = perm_round(state_reg, rc_lookup(cmd.rc_idx));
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        if (cmd.xfer)
        begin
            result_reg.out_word_0 <= state_reg[0];
            result_reg.out_word_1 <= state_reg[1];
            result_reg.out_word_2 <= state_reg[2];
            result_reg.out_word_3 <= state_reg[3];
            result_reg.out_word_4 <= state_reg[4];
        end
    end

    assign result = result_reg;

endmodule

@@ rtl/asconp_ctrl.sv @@
// Controller: round schedule counter, input handshake and result valid flag.
module asconp_ctrl #(
    parameter int unsigned MAX_ROUNDS = asconp_pkg::MAX_ROUNDS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [asconp_pkg::ROUND_CNT_W-1:0]   round_count,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output asconp_pkg::dp_cmd_t                  cmd
);
    import asconp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam logic [ROUND_CNT_W-1:0] MAX_N = ROUND_CNT_W'(MAX_ROUNDS);

    logic                   state_reg;
    logic                   state_next;
    logic [ROUND_CNT_W-1:0] idx_reg;
    logic [ROUND_CNT_W-1:0] idx_next;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    logic [ROUND_CNT_W-1:0] rounds_sat;
    logic                   done;

    assign rounds_sat = (round_count > MAX_N) ? MAX_N : round_count;
    assign done       = (idx_reg == LAST_IDX);

    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && item_valid;
        cmd.step   = (state_reg == ST_RUN) && !done;
        cmd.xfer   = (state_reg == ST_RUN) && done && (!result_valid_reg || !result_stall);
        cmd.rc_idx = idx_reg[RC_IDX_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    idx_next   = LAST_IDX - rounds_sat;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.step)
                begin
                    idx_next = idx_reg + ROUND_CNT_W'(1);
                end
                else if (cmd.xfer)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= LAST_IDX;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

@@ rtl/ascon_permutation_core.sv @@
// Top level of the round-iterative Ascon permutation core.
//
//  Channel  Direction  Handshake                    Beat contents
//  item     in         item_valid / item_stall      five state words and a round count
//  result   out        result_valid / result_stall  five permuted state words
//
// An item of n rounds (n being the round count, saturated to MAX_ROUNDS) is loaded,
// stepped through its n rounds and moved to the result register; the input stalls until
// then, so the next item is accepted only after that. The single shared round unit does
// one round per cycle on the state register. Reset clears only the controller;
// the state and result registers hold payload and need no reset. A stalled result is
// held in its own register, so the core may take and work on the next item meanwhile;
// it waits only when that item is finished and the earlier result has not been taken.
module ascon_permutation_core #(
    parameter int unsigned MAX_ROUNDS = asconp_pkg::MAX_ROUNDS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  asconp_pkg::item_beat_t    item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output asconp_pkg::result_beat_t  result
);
    import asconp_pkg::*;

    // Load, round step and result transfer commands, plus the table index for this round.
    dp_cmd_t cmd;

    // The controller walks the constant table from entry 16 - n up to its end.
    asconp_ctrl #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .round_count  (item.round_count),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    // The datapath applies one full round per step command.
    asconp_datapath u_datapath (
        .clk    (clk),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule

@@ verif/ascon_permutation_core_checker.sv @@
// Checker for the Ascon permutation core: predicts each result beat and compares it.
`timescale 1ns / 100ps

module ascon_permutation_core_checker
    import asconp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         item_stall,
    input  item_beat_t   item,
    input  logic         result_valid,
    input  logic         result_stall,
    input  result_beat_t result,
    output int           fail_count,
    output int           pending
);

    typedef logic [WORD_W-1:0] lane_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] lanes_t;

    localparam int unsigned ROUND_LIMIT = MAX_ROUNDS_DEFAULT;

    // Round constants; a run of n rounds uses the last n entries in order.
    localparam logic [0:15][7:0] ROUND_CONST = {
        8'h3c, 8'h2d, 8'h1e, 8'h0f, 8'hf0, 8'he1, 8'hd2, 8'hc3,
        8'hb4, 8'ha5, 8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
    };

    result_beat_t permuted_states [$];
    int           mismatches = 0;

    function automatic lane_t rotr(lane_t x, int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic result_beat_t permute_state(item_beat_t beat);
        lane_t        x [5];
        lane_t        t [5];
        int unsigned  n;
        int unsigned  r;
        int unsigned  k;
        result_beat_t p;
        x[0] = beat.word_0;
        x[1] = beat.word_1;
        x[2] = beat.word_2;
        x[3] = beat.word_3;
        x[4] = beat.word_4;
        n = (beat.round_count > ROUND_LIMIT) ? ROUND_LIMIT : beat.round_count;
        for (r = 0; r < n; r++)
        begin
            x[2] ^= {56'd0, ROUND_CONST[(16 - n + r) % 16]};
            // Bitsliced S-box across all 64 columns.
            x[0] ^= x[4];
            x[4] ^= x[3];
            x[2] ^= x[1];
            for (k = 0; k < 5; k++)
                t[k] = ~x[k] & x[(k + 1) % 5];
            for (k = 0; k < 5; k++)
                x[k] ^= t[(k + 1) % 5];
            x[1] ^= x[0];
            x[0] ^= x[4];
            x[3] ^= x[2];
            x[2] = ~x[2];
            // Linear diffusion.
            x[0] ^= rotr(x[0], 19) ^ rotr(x[0], 28);
            x[1] ^= rotr(x[1], 61) ^ rotr(x[1], 39);
            x[2] ^= rotr(x[2], 1) ^ rotr(x[2], 6);
            x[3] ^= rotr(x[3], 10) ^ rotr(x[3], 17);
            x[4] ^= rotr(x[4], 7) ^ rotr(x[4], 41);
        end
        p.out_word_0 = x[0];
        p.out_word_1 = x[1];
        p.out_word_2 = x[2];
        p.out_word_3 = x[3];
        p.out_word_4 = x[4];
        return p;
    endfunction

    always @(posedge clk)
    begin : watch
        lanes_t      want;
        lanes_t      got;
        int unsigned k;
        if (rst_n)
        begin
            // Retire the result first so that a beat taken in the same cycle
            // cannot stand in for a missing expectation.
            if (result_valid && !result_stall)
            begin
                if (permuted_states.size() == 0)
                begin
                    $error("result beat with nothing outstanding: %h", result);
                    mismatches++;
                end
                else
                begin
                    want = permuted_states.pop_front();
                    got  = result;
                    for (k = 0; k < NUM_WORDS; k++)
                    begin
                        if (got[NUM_WORDS-1-k] !== want[NUM_WORDS-1-k])
                        begin
                            $error("out_word_%0d: expected %h, actual %h", k,
                                   want[NUM_WORDS-1-k], got[NUM_WORDS-1-k]);
                            mismatches++;
                        end
                    end
                end
            end
            if (item_valid && !item_stall)
                permuted_states.push_back(permute_state(item));
        end
        fail_count <= mismatches;
        pending    <= permuted_states.size();
    end

endmodule

@@ verif/ascon_permutation_core_test.sv @@
// Top level of the Ascon permutation core testbench: clock, reset, beats and verdict.
`timescale 1ns / 100ps

module ascon_permutation_core_test;

    import asconp_pkg::*;

    // Each item is loaded, stepped through its n rounds, n being the saturated
    // round count, and then transferred. The drain after the last result lets
    // any stray beat appear.
    localparam int unsigned RANDOM_ITEMS   = 550;
    localparam int unsigned DRAIN_CYCLES   = 24;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned IDLE_PERCENT   = 25;

    // The receiver's long hold-off and its stretch without stalls, in cycles
    // counted from the end of reset.
    localparam int unsigned HOLD_START     = 700;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned CALM_RX_START  = 2000;
    localparam int unsigned CALM_RX_CYCLES = 1500;

    // Random items during which the sender never idles.
    localparam int unsigned CALM_TX_FIRST  = 200;
    localparam int unsigned CALM_TX_LAST   = 320;

    localparam logic [ROUND_CNT_W-1:0] FULL_ROUNDS = ROUND_CNT_W'(MAX_ROUNDS_DEFAULT);

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         item_valid   = 1'b0;
    logic         item_stall;
    item_beat_t   item         = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_beat_t result;

    int           fail_count;
    int           pending;
    int unsigned  cycle_count  = 0;
    int unsigned  rx_cycle     = 0;
    bit           sender_calm  = 1'b0;

    ascon_permutation_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    ascon_permutation_core_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one item beat, idling at random beforehand unless the sender is
    // in its calm stretch. Returns at the edge where the beat is accepted; the
    // stall seen just after the edge is the one that edge acted on.
    task automatic offer_item(input word_t w0, input word_t w1, input word_t w2,
                              input word_t w3, input word_t w4,
                              input logic [ROUND_CNT_W-1:0] rounds);
        item_beat_t beat;
        beat.word_0      = w0;
        beat.word_1      = w1;
        beat.word_2      = w2;
        beat.word_3      = w3;
        beat.word_4      = w4;
        beat.round_count = rounds;
        while (!sender_calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Mostly dense random words, with the all-zero, all-one and single-bit
    // patterns mixed in so the S-box sees degenerate columns as well.
    function automatic word_t random_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Weighted towards the usual twelve and the full sixteen rounds, with
    // zero and the over-range counts that saturate kept in the mix.
    function automatic logic [ROUND_CNT_W-1:0] random_rounds();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 35)
            return ROUND_CNT_W'(12);
        else if (pick < 50)
            return FULL_ROUNDS;
        else if (pick < 58)
            return '0;
        else if (pick < 88)
            return ROUND_CNT_W'($urandom_range(1, MAX_ROUNDS_DEFAULT));
        else
            return ROUND_CNT_W'($urandom_range(MAX_ROUNDS_DEFAULT + 1, 31));
    endfunction

    // Receiver: random stalls, one long hold-off that backs the core up until
    // it stalls its input, and a long stretch that takes every beat at once.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
                result_stall <= 1'b1;
            else if (rx_cycle >= CALM_RX_START && rx_cycle < CALM_RX_START + CALM_RX_CYCLES)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned i;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-zero state: pass-through, a single round, typical and full
        // schedules, and counts above the maximum that must saturate.
        offer_item('0, '0, '0, '0, '0, 5'd0);
        offer_item('0, '0, '0, '0, '0, 5'd1);
        offer_item('0, '0, '0, '0, '0, 5'd12);
        offer_item('0, '0, '0, '0, '0, FULL_ROUNDS);
        offer_item('0, '0, '0, '0, '0, 5'd17);
        offer_item('0, '0, '0, '0, '0, 5'd31);

        // All-one state.
        offer_item('1, '1, '1, '1, '1, 5'd0);
        offer_item('1, '1, '1, '1, '1, 5'd6);
        offer_item('1, '1, '1, '1, '1, 5'd12);
        offer_item('1, '1, '1, '1, '1, FULL_ROUNDS);
        offer_item('1, '1, '1, '1, '1, 5'd20);

        // Alternating bit patterns.
        offer_item({16{4'h5}}, {16{4'ha}}, {16{4'h5}}, {16{4'ha}}, {16{4'h5}}, 5'd8);
        offer_item({16{4'ha}}, {16{4'h5}}, {16{4'ha}}, {16{4'h5}}, {16{4'ha}}, FULL_ROUNDS);

        // A lone set bit in each word in turn, at either end of the word.
        offer_item(word_t'(1) << 63, '0, '0, '0, '0, 5'd1);
        offer_item('0, word_t'(1), '0, '0, '0, 5'd1);
        offer_item('0, '0, word_t'(1) << 63, '0, '0, 5'd2);
        offer_item('0, '0, '0, word_t'(1), '0, 5'd1);
        offer_item('0, '0, '0, '0, word_t'(1) << 63, 5'd2);

        // Mostly dense random states at short schedules.
        offer_item(random_word(), random_word(), random_word(), random_word(), random_word(), 5'd3);
        offer_item(random_word(), random_word(), random_word(), random_word(), random_word(), 5'd4);
        offer_item(random_word(), random_word(), random_word(), random_word(), random_word(), 5'd5);
        offer_item(random_word(), random_word(), random_word(), random_word(), random_word(), 5'd7);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            sender_calm = (i >= CALM_TX_FIRST && i < CALM_TX_LAST);
            offer_item(random_word(), random_word(), random_word(), random_word(),
                       random_word(), random_rounds());
        end

        // Drop valid and let the checker's count catch up with the last beat.
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
